// ===== hdl/fnpll_pkg.sv =====
`timescale 1ns / 1ps

package fnpll_pkg;

	// Field widths fixed by the register map and result word
	localparam int PFD_W       = 28;
	localparam int PFD_EFF_W   = 32;  // pfd_internal * prescaler
	localparam int PRE_W       = 4;
	localparam int DEN_W       = 25;
	localparam int N_W         = 16;
	localparam int NUM_W       = 24;
	localparam int DH_W        = 8;
	localparam int DL_W        = 16;
	localparam int DIV1_SEL_W  = 2;
	localparam int DIV2_SEL_W  = 3;
	localparam int CFG_IDX_W   = 3;

	// Fraction quotient is below den, so DEN_W quotient bits suffice
	localparam int NUM_STEPS   = DEN_W;
	localparam int PROD_W      = PFD_EFF_W + DEN_W;

	localparam logic [DIV1_SEL_W-1:0] DIV1_LAST = 2'd3;
	localparam logic [DIV2_SEL_W-1:0] DIV2_LAST = 3'd6;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PFD_INT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PFD_EXT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESCALER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEN       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VCO_MIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VCO_MAX   = 3'd5;

	// Reset values
	localparam logic [PFD_W-1:0] RST_PFD_INT   = 28'd84000000;
	localparam logic [PFD_W-1:0] RST_PFD_EXT   = 28'd16800000;
	localparam logic [PRE_W-1:0] RST_PRESCALER = 4'd2;
	localparam logic [DEN_W-1:0] RST_DEN       = 25'd1048576;
	localparam logic [63:0]      RST_VCO_MIN   = 64'd4200000000;
	localparam logic [63:0]      RST_VCO_MAX   = 64'd5520000000;

	typedef struct packed {
		logic load;          // capture request word
		logic search_step;   // test one divider pair
		logic div_load_n;    // start vco / pfd
		logic div_step;      // one restoring-division bit
		logic mul;           // remainder * den, latch N
		logic div_load_num;  // start fraction division
		logic fin;           // latch result word
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic last_cand;
		logic pfd_zero;
	} sts_t;

endpackage

// ===== hdl/fnpll_ctrl.sv =====
`timescale 1ns / 1ps

module fnpll_ctrl
	import fnpll_pkg::*;
#(
	parameter int FREQ_WIDTH = 33
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic use_internal_vco,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	localparam int CNT_W = $clog2(FREQ_WIDTH + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_PREP   = 3'd2;
	localparam logic [2:0] S_DIVN   = 3'd3;
	localparam logic [2:0] S_MUL    = 3'd4;
	localparam logic [2:0] S_LOADF  = 3'd5;
	localparam logic [2:0] S_DIVF   = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		done_d  = 1'b0;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = use_internal_vco ? S_SEARCH : S_PREP;
				end
			end
			S_SEARCH: begin
				cmd.search_step = 1'b1;
				if (sts.hit || sts.last_cand) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (sts.pfd_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.div_load_n = 1'b1;
					cnt_d          = CNT_W'(FREQ_WIDTH - 1);
					state_d        = S_DIVN;
				end
			end
			S_DIVN: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_MUL;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_LOADF;
			end
			S_LOADF: begin
				cmd.div_load_num = 1'b1;
				cnt_d            = CNT_W'(NUM_STEPS - 1);
				state_d          = S_DIVF;
			end
			S_DIVF: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_FIN;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== hdl/fnpll_dp.sv =====
`timescale 1ns / 1ps

module fnpll_dp
	import fnpll_pkg::*;
#(
	parameter int FREQ_WIDTH = 33
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  use_internal_vco,
	input  logic [FREQ_WIDTH-1:0] out_freq_hz,
	input  logic [PFD_W-1:0]      pfd_internal,
	input  logic [PFD_W-1:0]      pfd_external,
	input  logic [PRE_W-1:0]      prescaler,
	input  logic [DEN_W-1:0]      den,
	input  logic [FREQ_WIDTH-1:0] vco_min,
	input  logic [FREQ_WIDTH-1:0] vco_max,
	output logic                  divider_found,
	output logic [DIV1_SEL_W-1:0] chdiv1_index,
	output logic [DIV2_SEL_W-1:0] chdiv2_index,
	output logic [FREQ_WIDTH-1:0] vco_freq_hz,
	output logic [N_W-1:0]        pll_n,
	output logic [NUM_W-1:0]      pll_num,
	output logic [DH_W-1:0]       den_high,
	output logic [DL_W-1:0]       den_low
);

	localparam int BASE_W = FREQ_WIDTH + 3;   // freq * 7
	localparam int CAND_W = FREQ_WIDTH + 9;   // freq * 7 * 64
	localparam int DVD_W  = FREQ_WIDTH;       // >= NUM_STEPS over the range

	// search
	logic [FREQ_WIDTH-1:0] freq_q;
	logic [BASE_W-1:0]     base_q;
	logic [DIV1_SEL_W-1:0] i_q;
	logic [DIV2_SEL_W-1:0] j_q;
	logic [CAND_W-1:0]     cand;
	logic                  hit;

	// kept across words
	logic [FREQ_WIDTH-1:0] last_vco_q;
	logic [DIV1_SEL_W-1:0] last_div1_q;
	logic [DIV2_SEL_W-1:0] last_div2_q;
	logic                  found_q;

	// divider
	logic [PFD_EFF_W-1:0]  pfd_eff_q;
	logic [PFD_EFF_W-1:0]  rem_q;
	logic [DVD_W-1:0]      rq_q;
	logic [PFD_EFF_W:0]    trial;
	logic [PFD_EFF_W:0]    diff;
	logic                  ge;
	logic [PROD_W-1:0]     prod_q;
	logic [N_W-1:0]        n_q;

	// den split
	logic [DEN_W-17:0]     den_top;
	logic [DEN_W-17:0]     den_top_m1;
	logic [DH_W-1:0]       dh;
	logic [DL_W-1:0]       dl;

	assign cand = CAND_W'(base_q) << j_q;
	assign hit  = (cand > CAND_W'(vco_min)) && (cand < CAND_W'(vco_max));

	assign sts.hit       = hit;
	assign sts.last_cand = (i_q == DIV1_LAST) && (j_q == DIV2_LAST);
	assign sts.pfd_zero  = (pfd_eff_q == '0);

	assign trial = {rem_q, rq_q[DVD_W-1]};
	assign diff  = trial - {1'b0, pfd_eff_q};
	assign ge    = (trial >= {1'b0, pfd_eff_q});

	assign den_top    = den[DEN_W-1:16];
	assign den_top_m1 = den_top - 1'b1;

	always_comb begin
		if (den_top == '0) begin
			dh = '0;
			dl = den[DL_W-1:0];
		end else begin
			dh = den_top_m1[DEN_W-17] ? {DH_W{1'b1}} : den_top_m1[DH_W-1:0];
			dl = {DL_W{1'b1}};
		end
	end

	// stored VCO choice and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_vco_q  <= '0;
			last_div1_q <= '0;
			last_div2_q <= '0;
			found_q     <= 1'b0;
		end else if (cmd.load) begin
			found_q <= !use_internal_vco;
			if (!use_internal_vco) begin
				last_vco_q <= out_freq_hz;
			end
		end else if (cmd.search_step && hit) begin
			last_vco_q  <= cand[FREQ_WIDTH-1:0];
			last_div1_q <= i_q;
			last_div2_q <= j_q;
			found_q     <= 1'b1;
		end
	end

	// search walk and effective PFD
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			freq_q <= out_freq_hz;
			base_q <= BASE_W'(out_freq_hz) << 2;
			i_q    <= '0;
			j_q    <= '0;
			if (use_internal_vco) begin
				pfd_eff_q <= PFD_EFF_W'(pfd_internal) * PFD_EFF_W'(prescaler);
			end else begin
				pfd_eff_q <= PFD_EFF_W'(pfd_external);
			end
		end else if (cmd.search_step && !hit) begin
			if (i_q == DIV1_LAST) begin
				i_q    <= '0;
				j_q    <= j_q + 1'b1;
				base_q <= BASE_W'(freq_q) << 2;
			end else begin
				i_q    <= i_q + 1'b1;
				base_q <= base_q + BASE_W'(freq_q);
			end
		end
	end

	// shared restoring divider, remainder multiply
	always_ff @(posedge clk) begin
		if (cmd.div_load_n) begin
			rem_q <= '0;
			rq_q  <= last_vco_q;
		end else if (cmd.div_load_num) begin
			rem_q <= prod_q[PROD_W-1:NUM_STEPS];
			rq_q  <= {prod_q[NUM_STEPS-1:0], {(DVD_W-NUM_STEPS){1'b0}}};
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[PFD_EFF_W-1:0] : trial[PFD_EFF_W-1:0];
			rq_q  <= {rq_q[DVD_W-2:0], ge};
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(rem_q) * PROD_W'(den);
			n_q    <= (|rq_q[DVD_W-1:N_W]) ? {N_W{1'b1}} : rq_q[N_W-1:0];
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			divider_found <= found_q;
			chdiv1_index  <= last_div1_q;
			chdiv2_index  <= last_div2_q;
			vco_freq_hz   <= last_vco_q;
			den_high      <= dh;
			den_low       <= dl;
			if (sts.pfd_zero) begin
				pll_n   <= {N_W{1'b1}};
				pll_num <= '0;
			end else begin
				pll_n   <= n_q;
				pll_num <= rq_q[NUM_STEPS-1] ? {NUM_W{1'b1}} : rq_q[NUM_W-1:0];
			end
		end
	end

endmodule

// ===== hdl/frac_n_pll_divider_calc_top.sv =====
`timescale 1ns / 1ps

// Fractional-N PLL divider calculator. Pulse start with a word (target
// frequency and VCO mode) while busy is low; the word is taken on that edge
// and busy rises. With the internal VCO the block walks the 28 output
// divider pairs (chdiv2 outer, chdiv1 inner), one pair per cycle, and keeps
// the first whose VCO frequency lies strictly inside the limits; on a miss
// the previous VCO choice is reused and divider_found is 0. It then divides
// the VCO frequency by the effective PFD with a shared 1-bit-per-cycle
// restoring divider, multiplies the remainder by den and divides again for
// the numerator; a zero effective PFD skips the divisions. The result word
// is registered onto the output ports in the cycle that done is high, and
// holds until the next result; done is high for a single cycle, and busy
// falls in that same cycle; there is no way to hold the result off, so
// capture it on done. Registers are written through cfg_wr_en / cfg_index /
// cfg_data; the user must write them while the block is idle only, as the
// block itself does not enforce it.
module frac_n_pll_divider_calc_top
	import fnpll_pkg::*;
#(
	parameter int FREQ_WIDTH = 33
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command
	input  logic                  start,
	output logic                  busy,
	input  logic                  use_internal_vco,
	input  logic [FREQ_WIDTH-1:0] out_freq_hz,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [FREQ_WIDTH-1:0] cfg_data,
	// result word
	output logic                  done,
	output logic                  divider_found,
	output logic [DIV1_SEL_W-1:0] chdiv1_index,
	output logic [DIV2_SEL_W-1:0] chdiv2_index,
	output logic [FREQ_WIDTH-1:0] vco_freq_hz,
	output logic [N_W-1:0]        pll_n,
	output logic [NUM_W-1:0]      pll_num,
	output logic [DH_W-1:0]       den_high,
	output logic [DL_W-1:0]       den_low
);

	// Config registers
	logic [PFD_W-1:0]      pfd_internal_q;
	logic [PFD_W-1:0]      pfd_external_q;
	logic [PRE_W-1:0]      prescaler_q;
	logic [DEN_W-1:0]      den_q;
	logic [FREQ_WIDTH-1:0] vco_min_q;
	logic [FREQ_WIDTH-1:0] vco_max_q;

	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfd_internal_q <= RST_PFD_INT;
			pfd_external_q <= RST_PFD_EXT;
			prescaler_q    <= RST_PRESCALER;
			den_q          <= RST_DEN;
			vco_min_q      <= RST_VCO_MIN[FREQ_WIDTH-1:0];
			vco_max_q      <= RST_VCO_MAX[FREQ_WIDTH-1:0];
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PFD_INT:   pfd_internal_q <= cfg_data[PFD_W-1:0];
				REG_PFD_EXT:   pfd_external_q <= cfg_data[PFD_W-1:0];
				REG_PRESCALER: prescaler_q    <= cfg_data[PRE_W-1:0];
				REG_DEN:       den_q          <= cfg_data[DEN_W-1:0];
				REG_VCO_MIN:   vco_min_q      <= cfg_data;
				REG_VCO_MAX:   vco_max_q      <= cfg_data;
				default: begin
					// unmapped index: write dropped
				end
			endcase
		end
	end

	// Sequencer: search, divide, multiply, divide, publish
	fnpll_ctrl #(
		.FREQ_WIDTH(FREQ_WIDTH)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.use_internal_vco (use_internal_vco),
		.sts              (sts),
		.cmd              (cmd),
		.busy             (busy),
		.done             (done)
	);

	// Datapath: search walker, shared divider, multiplier, result registers
	fnpll_dp #(
		.FREQ_WIDTH(FREQ_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.use_internal_vco (use_internal_vco),
		.out_freq_hz      (out_freq_hz),
		.pfd_internal     (pfd_internal_q),
		.pfd_external     (pfd_external_q),
		.prescaler        (prescaler_q),
		.den              (den_q),
		.vco_min          (vco_min_q),
		.vco_max          (vco_max_q),
		.divider_found    (divider_found),
		.chdiv1_index     (chdiv1_index),
		.chdiv2_index     (chdiv2_index),
		.vco_freq_hz      (vco_freq_hz),
		.pll_n            (pll_n),
		.pll_num          (pll_num),
		.den_high         (den_high),
		.den_low          (den_low)
	);

endmodule

// ===== hdl/fnpll_chk.sv =====
`timescale 1ns / 1ps

module fnpll_chk
	import fnpll_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic [DIV2_SEL_W-1:0] chdiv2_index
);

	// accepted word keeps the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// busy drops only together with the result strobe
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	// one result per word, never back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// chdiv2 index stays inside the divider table
	a_div2_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (chdiv2_index <= DIV2_LAST))
		else $error("chdiv2 index out of range");

endmodule

bind frac_n_pll_divider_calc_top fnpll_chk u_fnpll_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.chdiv2_index     (chdiv2_index)
);
